FILE: sv/assert_macros.svh
// Assertion helpers for the acceleration pipeline
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Check an implication in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: sv/cgaa_pkg.sv
`timescale 1ns / 1ps
package cgaa_pkg;
   localparam int NSTAGE = 21;
   localparam int QCAP_BIT = 34;
   localparam logic [2:0] REG_G  = 3'd0;
   localparam logic [2:0] REG_M  = 3'd1;
   localparam logic [2:0] REG_CX = 3'd2;
   localparam logic [2:0] REG_CY = 3'd3;
   localparam logic [2:0] REG_CZ = 3'd4;
endpackage

FILE: sv/central_gravity_accel_add_top.sv
`timescale 1ns / 1ps
// Central point-mass gravity added to a particle acceleration.
// Input words arrive on req_ (tdata: pos_x, pos_y, pos_z, acc_in_x,
// acc_in_y, acc_in_z, 32 bits each from bit 0 up). Result words leave on
// rsp_ (tdata: acc_out_x, acc_out_y, acc_out_z; tuser: singular, saturated).
// Configuration words go to csr_ with a register index and 32-bit data:
// 0 grav_const, 1 body_mass, 2..4 center_x/y/z. Write only when idle.
// The pipeline takes one word per cycle unless stalled. Its stages from accept to
// rsp_tvalid: one offset stage, one square-sum stage, six root stages (six root bits
// each, four in the last), three product stages for D^3 and the numerators, nine
// quotient stages (four quotient bits each, two in the last) and the final add.
// The whole pipeline advances together; when rsp_tready is low and the last
// stage holds a word, every stage holds and req_tready falls, so nothing
// is lost or repeated. Synchronous reset clears all valid bits and restores
// the register defaults (G = M = 1.0, center at origin).
`include "assert_macros.svh"
module central_gravity_accel_add_top
   import cgaa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,  // pos_x, pos_y, pos_z, acc_in_x, acc_in_y, acc_in_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // acc_out_x, acc_out_y, acc_out_z
   output logic [1:0]   rsp_tuser,  // singular, saturated
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   logic [31:0] grav_ff, mass_ff;
   logic signed [31:0] cen_ff [3];
   logic [NSTAGE-1:0] vld_ff;
   logic adv;

   assign adv = !vld_ff[NSTAGE-1] || rsp_tready;
   assign req_tready = adv;
   assign csr_ready = 1'b1;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= 32'd65536;
         mass_ff <= 32'd65536;
         cen_ff[0] <= '0; cen_ff[1] <= '0; cen_ff[2] <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_G:  grav_ff <= csr_data;
            REG_M:  mass_ff <= csr_data;
            REG_CX: cen_ff[0] <= csr_data;
            REG_CY: cen_ff[1] <= csr_data;
            REG_CZ: cen_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NSTAGE-2:0], req_tvalid};
   end

   // Stage 1: offsets from the center and acc_in
   logic signed [32:0] d1_ff [3];
   logic [31:0] a1_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            d1_ff[k] <= $signed({req_tdata[32*k+31], req_tdata[32*k +: 32]})
                      - $signed({cen_ff[k][31], cen_ff[k]});
            a1_ff[k] <= req_tdata[96+32*k +: 32];
         end
      end
   end
   logic [32:0] m1 [3];
   always_comb begin
      for (int k = 0; k < 3; k++)
         m1[k] = d1_ff[k][32] ? 33'(-d1_ff[k]) : 33'(d1_ff[k]);
   end

   // Stage 2: sum of squares, G*M; stages 3..8: restoring square root,
   // six root bits a stage, four in the last
   localparam int RST = 6;
   localparam int RBITS = 6;
   logic [67:0] rs_ff [RST+1];
   logic [33:0] rq_ff [RST+1];
   logic [35:0] rr_ff [RST+1];
   logic [63:0] gm_ff [RST+1];
   logic [32:0] mm_ff [RST+1][3];
   logic [2:0] sg_ff [RST+1], nz_ff [RST+1];
   logic [31:0] aa_ff [RST+1][3];
   always_ff @(posedge clock) begin
      logic [67:0] s_t;
      logic [33:0] q_t;
      logic [35:0] r_t, t_t;
      if (adv) begin
         rs_ff[0] <= 68'(66'(m1[0]) * m1[0]) + 68'(66'(m1[1]) * m1[1])
                   + 68'(66'(m1[2]) * m1[2]);
         rq_ff[0] <= '0;
         rr_ff[0] <= '0;
         gm_ff[0] <= 64'(grav_ff) * mass_ff;
         for (int k = 0; k < 3; k++) begin
            mm_ff[0][k] <= m1[k];
            sg_ff[0][k] <= d1_ff[k][32];
            nz_ff[0][k] <= (d1_ff[k] != '0);
            aa_ff[0][k] <= a1_ff[k];
         end
         for (int g = 0; g < RST; g++) begin
            s_t = rs_ff[g]; q_t = rq_ff[g]; r_t = rr_ff[g]; t_t = '0;
            for (int b = 0; b < RBITS; b++) begin
               if (g*RBITS + b < 34) begin
                  r_t = {r_t[33:0], s_t[67:66]};
                  s_t = {s_t[65:0], 2'b00};
                  t_t = {q_t, 2'b01};
                  if (r_t >= t_t) begin
                     r_t = r_t - t_t;
                     q_t = {q_t[32:0], 1'b1};
                  end else q_t = {q_t[32:0], 1'b0};
               end
            end
            rs_ff[g+1] <= s_t; rq_ff[g+1] <= q_t; rr_ff[g+1] <= r_t;
            gm_ff[g+1] <= gm_ff[g]; sg_ff[g+1] <= sg_ff[g]; nz_ff[g+1] <= nz_ff[g];
            for (int k = 0; k < 3; k++) begin
               mm_ff[g+1][k] <= mm_ff[g][k]; aa_ff[g+1][k] <= aa_ff[g][k];
            end
         end
      end
   end

   // Stage 9: D^2 and the split G*M*|d| partial products
   logic [67:0] dsq_ff; logic [33:0] dr_ff;
   logic [64:0] nlo_ff [3], nhi_ff [3];
   logic [2:0] sg9_ff, nz9_ff; logic [31:0] a9_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         dsq_ff <= 68'(rq_ff[RST]) * rq_ff[RST];
         dr_ff <= rq_ff[RST];
         for (int k = 0; k < 3; k++) begin
            nlo_ff[k] <= 65'(gm_ff[RST][31:0]) * mm_ff[RST][k];
            nhi_ff[k] <= 65'(gm_ff[RST][63:32]) * mm_ff[RST][k];
            a9_ff[k] <= aa_ff[RST][k];
         end
         sg9_ff <= sg_ff[RST]; nz9_ff <= nz_ff[RST];
      end
   end

   // Stage 10: D^3 halves and G*M*|d|<<16
   logic [67:0] plo_ff, phi_ff; logic [112:0] num_ff [3];
   logic [2:0] sg10_ff, nz10_ff; logic [31:0] a10_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         plo_ff <= 68'(dsq_ff[33:0]) * dr_ff;
         phi_ff <= 68'(dsq_ff[67:34]) * dr_ff;
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= (113'(nhi_ff[k]) << 48) + (113'(nlo_ff[k]) << 16);
            a10_ff[k] <= a9_ff[k];
         end
         sg10_ff <= sg9_ff; nz10_ff <= nz9_ff;
      end
   end

   // Stage 11: D^3; stages 12..20: cap check and restoring division,
   // four quotient bits a stage (two in the last), most significant first
   localparam int DBITS = 4;
   localparam int DST = (QCAP_BIT + DBITS - 1) / DBITS;
   logic [101:0] dv_d3_ff [DST+1];
   logic [112:0] dv_rem_ff [DST+1][3];
   logic [QCAP_BIT-1:0] dv_q_ff [DST+1][3];
   logic [2:0] cap_ff [DST+1], dsg_ff [DST+1], dnz_ff [DST+1];
   logic [31:0] da_ff [DST+1][3];
   always_ff @(posedge clock) begin
      logic [112:0] rem_t;
      logic [QCAP_BIT-1:0] qb_t;
      logic [135:0] dt_t;
      logic ge;
      if (adv) begin
         dv_d3_ff[0] <= (102'(phi_ff) << 34) + 102'(plo_ff);
         cap_ff[0] <= '0;
         dsg_ff[0] <= sg10_ff; dnz_ff[0] <= nz10_ff;
         for (int k = 0; k < 3; k++) begin
            dv_rem_ff[0][k] <= num_ff[k];
            dv_q_ff[0][k] <= '0;
            da_ff[0][k] <= a10_ff[k];
         end
         for (int g = 0; g < DST; g++) begin
            dv_d3_ff[g+1] <= dv_d3_ff[g];
            dsg_ff[g+1] <= dsg_ff[g]; dnz_ff[g+1] <= dnz_ff[g];
            for (int k = 0; k < 3; k++) begin
               rem_t = dv_rem_ff[g][k]; qb_t = dv_q_ff[g][k];
               if (g == 0)
                  cap_ff[g+1][k] <= (136'(rem_t) >= (136'(dv_d3_ff[g]) << QCAP_BIT));
               else cap_ff[g+1][k] <= cap_ff[g][k];
               for (int b = 0; b < DBITS; b++) begin
                  if (g*DBITS + b < QCAP_BIT) begin
                     dt_t = 136'(dv_d3_ff[g]) << (QCAP_BIT - 1 - g*DBITS - b);
                     ge = (136'(rem_t) >= dt_t);
                     if (ge) rem_t = rem_t - 113'(dt_t);
                     qb_t = {qb_t[QCAP_BIT-2:0], ge};
                  end
               end
               dv_rem_ff[g+1][k] <= rem_t;
               dv_q_ff[g+1][k] <= qb_t;
               da_ff[g+1][k] <= da_ff[g][k];
            end
         end
      end
   end

   // Stage 21: add and saturate
   logic [95:0] out_ff; logic [1:0] usr_ff;
   always_ff @(posedge clock) begin
      logic signed [36:0] sm;
      logic [QCAP_BIT:0] qf;
      logic sat;
      if (adv) begin
         sat = 1'b0;
         for (int k = 0; k < 3; k++) begin
            qf = cap_ff[DST][k] ? ((QCAP_BIT+1)'(1) << QCAP_BIT)
                                : {1'b0, dv_q_ff[DST][k]};
            sm = 37'(signed'(da_ff[DST][k]));
            if (dnz_ff[DST][k]) begin
               if (dsg_ff[DST][k]) sm = sm + $signed({2'b00, qf});
               else sm = sm - $signed({2'b00, qf});
            end
            if (sm > 37'sd2147483647) begin
               out_ff[32*k +: 32] <= 32'h7fffffff; sat = 1'b1;
            end else if (sm < -37'sd2147483648) begin
               out_ff[32*k +: 32] <= 32'h80000000; sat = 1'b1;
            end else out_ff[32*k +: 32] <= sm[31:0];
         end
         if (dnz_ff[DST] == '0) usr_ff <= 2'b01;
         else usr_ff <= {sat, 1'b0};
      end
   end

   assign rsp_tvalid = vld_ff[NSTAGE-1];
   assign rsp_tdata = out_ff;
   assign rsp_tuser = usr_ff;

   `ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid,
      "result dropped under stall")
   `ASSERT_IMPL(a_ready, clock, reset, vld_ff[NSTAGE-1] && !rsp_tready, !req_tready,
      "input taken while stalled")
   `ASSERT_IMPL(a_flags, clock, reset, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]),
      "singular and saturated both set")
endmodule
